[hdl/triangle_tangent_space_macros.svh]
// assertion macros for the tangent space block
`ifndef TRIANGLE_TANGENT_SPACE_MACROS_SVH
`define TRIANGLE_TANGENT_SPACE_MACROS_SVH
`ifndef SYNTHESIS
`define TTS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TTS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hdl/tts_pkg.sv]
// shared types and constants for the tangent space block
package tts_pkg;
  localparam int unsigned POS_W = 32;
  localparam int unsigned TEX_W = 16;
  localparam int unsigned DET_W = 35;
  localparam int unsigned NUM_W = 52;
  localparam int unsigned QUO_W = 34;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_DET,
    ST_NUM,
    ST_DIV,
    ST_STORE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       take_corner;
    logic       calc_det;
    logic       calc_num;
    logic       div_start;
    logic       store_quo;
    logic       out_load;
    logic [2:0] comp_sel;
  } cmd_t;

  typedef struct packed {
    logic       det_zero;
    logic       div_done;
    logic [1:0] corner_cnt;
  } sts_t;
endpackage

[hdl/tts_if.sv]
// valid/ready channel with a generic payload
interface tts_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/tts_ctrl.sv]
// controller state machine for the tangent space block
module tts_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            out_ready,
  output logic            out_valid,
  input  tts_pkg::sts_t   sts,
  output tts_pkg::cmd_t   cmd
);
  tts_pkg::state_t state_r, state_nxt;
  logic [2:0] comp_r, comp_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tts_pkg::ST_COLLECT;
      comp_r  <= 3'd0;
    end else begin
      state_r <= state_nxt;
      comp_r  <= comp_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    comp_nxt  = comp_r;
    unique case (state_r)
      tts_pkg::ST_COLLECT: begin
        if (in_valid && sts.corner_cnt == 2'd2) state_nxt = tts_pkg::ST_DET;
      end
      tts_pkg::ST_DET: begin
        comp_nxt  = 3'd0;
        state_nxt = tts_pkg::ST_NUM;
      end
      tts_pkg::ST_NUM: begin
        if (sts.det_zero) state_nxt = tts_pkg::ST_OUT;
        else state_nxt = tts_pkg::ST_DIV;
      end
      tts_pkg::ST_DIV: begin
        if (sts.div_done) state_nxt = tts_pkg::ST_STORE;
      end
      tts_pkg::ST_STORE: begin
        if (comp_r == 3'd5) begin
          state_nxt = tts_pkg::ST_OUT;
        end else begin
          comp_nxt  = comp_r + 3'd1;
          state_nxt = tts_pkg::ST_NUM;
        end
      end
      tts_pkg::ST_OUT: begin
        if (out_ready) state_nxt = tts_pkg::ST_COLLECT;
      end
      default: state_nxt = tts_pkg::ST_COLLECT;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.comp_sel = comp_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      tts_pkg::ST_COLLECT: begin
        in_ready = 1'b1;
        cmd.take_corner = in_valid;
      end
      tts_pkg::ST_DET:   cmd.calc_det = 1'b1;
      tts_pkg::ST_NUM: begin
        cmd.calc_num  = 1'b1;
        cmd.div_start = !sts.det_zero;
      end
      tts_pkg::ST_DIV:   ;
      tts_pkg::ST_STORE: cmd.store_quo = 1'b1;
      tts_pkg::ST_OUT:   out_valid = 1'b1;
      default: ;
    endcase
  end
endmodule

[hdl/tts_div.sv]
// serial restoring divider, one quotient bit per cycle
module tts_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tts_pkg::NUM_W+14:0] dividend,
  input  logic [tts_pkg::DET_W:0]    divisor,
  output logic                       done,
  output logic [tts_pkg::QUO_W-1:0]  quotient
);
  localparam int unsigned DW = tts_pkg::NUM_W + 15;
  localparam int unsigned RW = tts_pkg::DET_W + 2;
  logic [DW-1:0] num_r;
  logic [RW-1:0] rem_r;
  logic [tts_pkg::DET_W:0] den_r;
  logic [6:0] cnt_r;
  logic busy_r;
  logic [RW-1:0] trial;
  logic [RW:0] diff;

  assign trial = {rem_r[RW-2:0], num_r[DW-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 7'(DW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      if (!diff[RW]) begin
        rem_r <= diff[RW-1:0];
        num_r <= {num_r[DW-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        num_r <= {num_r[DW-2:0], 1'b0};
      end
    end
  end

  assign done = !busy_r && !start;
  // the quotient is 67 bits wide; saturate values that do not fit 34 bits
  assign quotient = (|num_r[DW-1:tts_pkg::QUO_W]) ? '1 : num_r[tts_pkg::QUO_W-1:0];
endmodule

[hdl/tts_dp.sv]
// datapath: held corners, deltas, numerators, rounding and saturation
module tts_dp #(
  parameter int unsigned POS_FRAC_BITS = 16,
  parameter int unsigned TEX_FRAC_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tts_pkg::cmd_t                cmd,
  output tts_pkg::sts_t                sts,
  input  logic signed [31:0]           in_px, in_py, in_pz,
  input  logic signed [15:0]           in_tu, in_tv,
  output logic [5:0][31:0]             vec,
  output logic                         degen
);
  localparam int unsigned NW = tts_pkg::NUM_W;
  localparam int unsigned DIVW = tts_pkg::NUM_W + 15;
  logic signed [31:0] p0_r [3];
  logic signed [31:0] p1_r [3];
  logic signed [31:0] p2_r [3];
  logic signed [15:0] t_r [6];
  logic [1:0] cnt_r;
  logic signed [16:0] du1, dvv1, du2, dvv2;
  logic signed [33:0] pd_a, pd_b;
  logic signed [34:0] det_nxt;
  logic signed [34:0] det_r;
  logic signed [33:0] e1, e2;
  logic signed [33:0] ea, eb;
  logic signed [50:0] pn_a, pn_b;
  logic signed [NW-1:0] num_r;
  logic signed [16:0] ca, cb;
  logic [1:0] ax;
  logic [5:0][31:0] vec_r;
  logic degen_r;
  logic div_done;
  logic [tts_pkg::QUO_W-1:0] quo;
  logic [NW-1:0] nabs;
  logic [tts_pkg::DET_W:0] dabs;
  logic [31:0] sat;
  logic div_go_r;
  logic unused;

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= 2'd0;
    else if (cmd.take_corner) cnt_r <= (cnt_r == 2'd2) ? 2'd0 : cnt_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        p0_r[i] <= '0; p1_r[i] <= '0;
      end
      for (int i = 0; i < 6; i++) t_r[i] <= '0;
    end else if (cmd.take_corner) begin
      unique case (cnt_r)
        2'd0: begin
          p0_r[0] <= in_px; p0_r[1] <= in_py; p0_r[2] <= in_pz;
          t_r[0] <= in_tu; t_r[1] <= in_tv;
        end
        2'd1: begin
          p1_r[0] <= in_px; p1_r[1] <= in_py; p1_r[2] <= in_pz;
          t_r[2] <= in_tu; t_r[3] <= in_tv;
        end
        default: begin
          p2_r[0] <= in_px; p2_r[1] <= in_py; p2_r[2] <= in_pz;
          t_r[4] <= in_tu; t_r[5] <= in_tv;
        end
      endcase
    end
  end

  assign du1  = 17'(t_r[2]) - 17'(t_r[0]);
  assign dvv1 = 17'(t_r[3]) - 17'(t_r[1]);
  assign du2  = 17'(t_r[4]) - 17'(t_r[0]);
  assign dvv2 = 17'(t_r[5]) - 17'(t_r[1]);

  // full-width products so nothing wraps before the subtract
  assign pd_a    = du1 * dvv2;
  assign pd_b    = du2 * dvv1;
  assign det_nxt = 35'(pd_a) - 35'(pd_b);

  always_ff @(posedge clk) begin
    if (cmd.calc_det) det_r <= det_nxt;
  end

  // component select: 0..2 tangent, 3..5 bitangent
  always_comb begin
    ax = (cmd.comp_sel >= 3'd3) ? 2'(cmd.comp_sel - 3'd3) : cmd.comp_sel[1:0];
    e1 = 34'(p1_r[ax]) - 34'(p0_r[ax]);
    e2 = 34'(p2_r[ax]) - 34'(p0_r[ax]);
    if (cmd.comp_sel >= 3'd3) begin
      ca = du1; cb = du2;
      ea = e2;  eb = e1;
    end else begin
      ca = dvv2; cb = dvv1;
      ea = e1;   eb = e2;
    end
    pn_a = ca * ea;
    pn_b = cb * eb;
  end

  // tangent: dvv2*e1 - dvv1*e2 ; bitangent: du1*e2 - du2*e1
  always_ff @(posedge clk) begin
    if (cmd.calc_num) num_r <= NW'(pn_a) - NW'(pn_b);
  end

  assign nabs = num_r[NW-1] ? NW'(-num_r) : num_r;
  assign dabs = det_r[34] ? 36'(-det_r) : 36'(det_r);
  always_ff @(posedge clk) begin
    if (!rst_n) div_go_r <= 1'b0;
    else div_go_r <= cmd.div_start;
  end

  // (2n*2^tf + d) / 2d
  tts_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_go_r),
    .dividend((DIVW'({nabs, 1'b0}) << TEX_FRAC_BITS) + DIVW'(dabs)),
    .divisor({dabs[34:0], 1'b0}),
    .done(div_done), .quotient(quo)
  );

  always_comb begin
    if (num_r[NW-1] != det_r[34]) sat = (quo >= 34'h80000000) ? 32'h80000000
                                       : 32'(-quo);
    else sat = (quo > 34'h7FFFFFFF) ? 32'h7FFFFFFF : quo[31:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_det) begin
      vec_r   <= '0;
      degen_r <= det_nxt == '0;
    end else if (cmd.store_quo) begin
      vec_r[cmd.comp_sel] <= (quo == '0) ? 32'd0 : sat;
    end
  end

  assign sts.det_zero   = degen_r;
  assign sts.div_done   = div_done && !div_go_r;
  assign sts.corner_cnt = cnt_r;
  assign vec   = vec_r;
  assign degen = degen_r;
  assign unused = POS_FRAC_BITS[0];
endmodule

[hdl/triangle_tangent_space.sv]
// top level: per-triangle tangent and bitangent in fixed point
// corners one per cycle while collecting; the third corner starts the result computation
// the wait for a result after the third corner is set mostly by the serial divider
// one divide per vector component, 67 quotient bits each; a degenerate triangle skips the divides
// corners of the next triangle are taken only after the last result is accepted
// synchronous active-low reset clears the corner count and held corners, but not the third corner's position
`include "triangle_tangent_space_macros.svh"
module triangle_tangent_space #(
  parameter int unsigned POS_FRAC_BITS = 16,
  parameter int unsigned TEX_FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [15:0] in_tex_u,
  input  logic signed [15:0] in_tex_v,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_tangent_x,
  output logic signed [31:0] out_tangent_y,
  output logic signed [31:0] out_tangent_z,
  output logic signed [31:0] out_bitangent_x,
  output logic signed [31:0] out_bitangent_y,
  output logic signed [31:0] out_bitangent_z,
  output logic               out_degenerate
);
  tts_pkg::cmd_t cmd;
  tts_pkg::sts_t sts;
  logic [5:0][31:0] vec;

  // controller sequences collect, determinant, six divides (skipped if degenerate), output
  tts_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_ready(out_ready), .out_valid(out_valid), .sts(sts), .cmd(cmd)
  );

  // datapath holds corners and runs the shared divider
  tts_dp #(.POS_FRAC_BITS(POS_FRAC_BITS), .TEX_FRAC_BITS(TEX_FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_px(in_pos_x), .in_py(in_pos_y), .in_pz(in_pos_z),
    .in_tu(in_tex_u), .in_tv(in_tex_v), .vec(vec), .degen(out_degenerate)
  );

  assign out_tangent_x   = vec[0];
  assign out_tangent_y   = vec[1];
  assign out_tangent_z   = vec[2];
  assign out_bitangent_x = vec[3];
  assign out_bitangent_y = vec[4];
  assign out_bitangent_z = vec[5];

  // a transaction out never overlaps one coming in
  `TTS_ASSERT_IMPL(a_no_overlap, clk, rst_n, out_valid, !in_ready)
  // degenerate result carries zero vectors
  `TTS_ASSERT_IMPL(a_degen_zero, clk, rst_n, out_valid && out_degenerate, vec == '0)
  // stalled result holds its vectors
  `TTS_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(vec))
endmodule

[tb/triangle_tangent_space_test.sv]
// self-checking testbench for the per-triangle tangent and bitangent block
`timescale 1ns / 100ps
module triangle_tangent_space_test;
  localparam int unsigned POS_FRAC = 16;
  localparam int unsigned TEX_FRAC = 12;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned LONG_HOLD = 1500;
  localparam int unsigned DRAIN_CYCLES = 600;  // about one triangle of divider work
  localparam int unsigned MAX_SHOWN = 10;

  // payload of one corner transaction
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] tex_u;
    logic signed [15:0] tex_v;
  } corner_t;

  // payload of one result transaction
  typedef struct packed {
    logic signed [31:0] tangent_x;
    logic signed [31:0] tangent_y;
    logic signed [31:0] tangent_z;
    logic signed [31:0] bitangent_x;
    logic signed [31:0] bitangent_y;
    logic signed [31:0] bitangent_z;
    logic               degenerate;
  } frame_t;

  // triangle shapes for the random part
  typedef enum int {
    TRI_FULL_RANGE,
    TRI_MODEST,
    TRI_FLAT_TEX,
    TRI_COLLINEAR_TEX
  } tri_kind_t;

  logic clk;
  logic rst_n;

  tts_if #(.payload_t(corner_t)) corner_ch ();
  tts_if #(.payload_t(frame_t))  frame_ch ();

  triangle_tangent_space #(
    .POS_FRAC_BITS(POS_FRAC),
    .TEX_FRAC_BITS(TEX_FRAC)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (corner_ch.valid),
    .in_ready       (corner_ch.ready),
    .in_pos_x       (corner_ch.data.pos_x),
    .in_pos_y       (corner_ch.data.pos_y),
    .in_pos_z       (corner_ch.data.pos_z),
    .in_tex_u       (corner_ch.data.tex_u),
    .in_tex_v       (corner_ch.data.tex_v),
    .out_valid      (frame_ch.valid),
    .out_ready      (frame_ch.ready),
    .out_tangent_x  (frame_ch.data.tangent_x),
    .out_tangent_y  (frame_ch.data.tangent_y),
    .out_tangent_z  (frame_ch.data.tangent_z),
    .out_bitangent_x(frame_ch.data.bitangent_x),
    .out_bitangent_y(frame_ch.data.bitangent_y),
    .out_bitangent_z(frame_ch.data.bitangent_z),
    .out_degenerate (frame_ch.data.degenerate)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state: the two held corners and how many were taken
  corner_t held_corner [2];
  int      corners_held;
  frame_t  expected_frames [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatches;
  int unsigned hold_asked;
  int unsigned hold_served;
  int unsigned hold_left;
  int unsigned quiet_cycles;

  // num * 2^TEX_FRAC / den, rounded half away from zero, clamped to 32 bits
  function automatic logic [31:0] rounded_quotient(longint num, longint den);
    logic [63:0] n_mag;
    logic [63:0] d_mag;
    logic [63:0] q;
    logic        neg;
    n_mag = (num < 0) ? 64'(-num) : 64'(num);
    d_mag = (den < 0) ? 64'(-den) : 64'(den);
    neg = (num < 0) != (den < 0);
    q = ((n_mag << (TEX_FRAC + 1)) + d_mag) / (d_mag << 1);
    if (q == 0) return 32'd0;
    if (neg) return (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-q);
    return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
  endfunction

  // update the held corners; on the third corner queue the expected frame
  function automatic void predict_corner(corner_t c);
    longint edge1 [3];
    longint edge2 [3];
    longint du1, dv1, du2, dv2, det_val;
    frame_t f;
    if (corners_held < 2) begin
      held_corner[corners_held] = c;
      corners_held++;
      return;
    end
    corners_held = 0;
    edge1[0] = longint'(held_corner[1].pos_x) - longint'(held_corner[0].pos_x);
    edge1[1] = longint'(held_corner[1].pos_y) - longint'(held_corner[0].pos_y);
    edge1[2] = longint'(held_corner[1].pos_z) - longint'(held_corner[0].pos_z);
    edge2[0] = longint'(c.pos_x) - longint'(held_corner[0].pos_x);
    edge2[1] = longint'(c.pos_y) - longint'(held_corner[0].pos_y);
    edge2[2] = longint'(c.pos_z) - longint'(held_corner[0].pos_z);
    du1 = longint'(held_corner[1].tex_u) - longint'(held_corner[0].tex_u);
    dv1 = longint'(held_corner[1].tex_v) - longint'(held_corner[0].tex_v);
    du2 = longint'(c.tex_u) - longint'(held_corner[0].tex_u);
    dv2 = longint'(c.tex_v) - longint'(held_corner[0].tex_v);
    det_val = du1 * dv2 - du2 * dv1;
    f = '0;
    if (det_val == 0) begin
      // zero determinant: flag set, vectors zero
      f.degenerate = 1'b1;
    end else begin
      f.tangent_x   = rounded_quotient(dv2 * edge1[0] - dv1 * edge2[0], det_val);
      f.tangent_y   = rounded_quotient(dv2 * edge1[1] - dv1 * edge2[1], det_val);
      f.tangent_z   = rounded_quotient(dv2 * edge1[2] - dv1 * edge2[2], det_val);
      f.bitangent_x = rounded_quotient(du1 * edge2[0] - du2 * edge1[0], det_val);
      f.bitangent_y = rounded_quotient(du1 * edge2[1] - du2 * edge1[1], det_val);
      f.bitangent_z = rounded_quotient(du1 * edge2[2] - du2 * edge1[2], det_val);
    end
    expected_frames = {expected_frames, f};
  endfunction

  // offer one corner at the falling edge, hold it until the transaction happens
  task automatic send_corner(corner_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      corner_ch.valid <= 1'b0;
    end
    @(negedge clk);
    corner_ch.valid <= 1'b1;
    corner_ch.data  <= c;
    do @(posedge clk); while (!corner_ch.ready);
    predict_corner(c);
  endtask

  task automatic send_triangle(corner_t a, corner_t b, corner_t c);
    send_corner(a);
    send_corner(b);
    send_corner(c);
  endtask

  function automatic corner_t random_corner(bit modest);
    corner_t c;
    c = {$urandom, $urandom, $urandom, 16'($urandom), 16'($urandom)};
    if (modest) begin
      // up to 16 units in position and up to 2 in texture space
      c.pos_x = 32'(signed'(21'(c.pos_x)));
      c.pos_y = 32'(signed'(21'(c.pos_y)));
      c.pos_z = 32'(signed'(21'(c.pos_z)));
      c.tex_u = 16'(signed'(14'(c.tex_u)));
      c.tex_v = 16'(signed'(14'(c.tex_v)));
    end
    return c;
  endfunction

  task automatic send_random_triangle(tri_kind_t kind);
    corner_t a, b, c;
    a = random_corner(kind != TRI_FULL_RANGE);
    b = random_corner(kind != TRI_FULL_RANGE);
    c = random_corner(kind != TRI_FULL_RANGE);
    if (kind == TRI_FLAT_TEX) begin
      // all texture coordinates equal
      b.tex_u = a.tex_u; b.tex_v = a.tex_v;
      c.tex_u = a.tex_u; c.tex_v = a.tex_v;
    end else if (kind == TRI_COLLINEAR_TEX) begin
      // third texture delta is twice the first
      c.tex_u = 16'(2 * b.tex_u - a.tex_u);
      c.tex_v = 16'(2 * b.tex_v - a.tex_v);
    end
    send_triangle(a, b, c);
  endtask

  // drop valid so the last corner is not offered again, then drain
  task automatic wait_for_frames();
    @(negedge clk);
    corner_ch.valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
  endtask

  // corner cases: field extremes, degenerate texture, saturation, rounding
  task automatic test_directed();
    corner_t z, pmax, pmin, tx;
    z = '0;
    pmax = {32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sh7FFF, 16'sh7FFF};
    pmin = {32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 16'sh8000, 16'sh8000};
    // unit right triangle, texture matches position
    tx = z; tx.pos_x = 32'sh0001_0000; tx.tex_u = 16'sh1000;
    send_triangle(z, tx, '{pos_x: 0, pos_y: 32'sh0001_0000, pos_z: 0,
                           tex_u: 0, tex_v: 16'sh1000});
    // texture corners on one line: degenerate
    send_triangle(pmax, pmin, z);
    // extreme edges over the smallest texture step: saturates at the positive limit
    send_triangle(pmin, '{pos_x: 32'sh7FFF_FFFF, pos_y: 32'sh8000_0000,
                          pos_z: 32'sh7FFF_FFFF, tex_u: 16'sh8001, tex_v: 16'sh8000},
                  '{pos_x: 32'sh8000_0000, pos_y: 32'sh7FFF_FFFF, pos_z: 0,
                    tex_u: 16'sh8000, tex_v: 16'sh8001});
    // largest texture deltas
    send_triangle('{pos_x: 5, pos_y: -7, pos_z: 3, tex_u: 16'sh8000, tex_v: 16'sh8000},
                  '{pos_x: -1, pos_y: 9, pos_z: -2, tex_u: 16'sh7FFF, tex_v: 16'sh8000},
                  '{pos_x: 2, pos_y: 1, pos_z: 11, tex_u: 16'sh8000, tex_v: 16'sh7FFF});
    // tiny results: rounding to zero and ties
    send_triangle(z, '{pos_x: 1, pos_y: -1, pos_z: 3, tex_u: 16'sh7FFF, tex_v: 0},
                  '{pos_x: -3, pos_y: 2, pos_z: 1, tex_u: 0, tex_v: 16'sh7FFF});
    send_triangle(z, '{pos_x: 1, pos_y: 1, pos_z: -1, tex_u: 16'sh2000, tex_v: 0},
                  '{pos_x: 0, pos_y: -1, pos_z: 1, tex_u: 0, tex_v: 16'sh2000});
    // collinear texture, nonzero positions
    send_triangle(pmax, '{pos_x: 1, pos_y: 2, pos_z: 3, tex_u: 16'sh7FFF, tex_v: 16'sh7FFF},
                  '{pos_x: 4, pos_y: 5, pos_z: 6, tex_u: 16'sh7FFF, tex_v: 16'sh7FFF});
    send_triangle(pmax, pmax, pmin);
    wait_for_frames();
  endtask

  task automatic test_random(int unsigned triangles, int unsigned s_idle, int unsigned r_idle);
    int r;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int i = 0; i < triangles; i++) begin
      r = $urandom_range(99);
      if (r < 40)      send_random_triangle(TRI_FULL_RANGE);
      else if (r < 80) send_random_triangle(TRI_MODEST);
      else if (r < 90) send_random_triangle(TRI_FLAT_TEX);
      else             send_random_triangle(TRI_COLLINEAR_TEX);
    end
    wait_for_frames();
  endtask

  // receiver stalls for a long stretch while corners are still offered
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_asked++;
    for (int i = 0; i < 10; i++) send_random_triangle(TRI_MODEST);
    wait_for_frames();
  endtask

  // receiver: random ready, or a long hold when one is asked for
  always @(negedge clk) begin
    if (!rst_n) begin
      frame_ch.ready <= 1'b0;
    end else if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left = LONG_HOLD;
      frame_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      frame_ch.ready <= 1'b0;
    end else begin
      frame_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    frame_t want;
    if (rst_n && frame_ch.valid && frame_ch.ready) begin
      if (expected_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected result transaction: %p", frame_ch.data);
      end else begin
        want = expected_frames.pop_front();
        if (frame_ch.data !== want) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("result mismatch\n  expected %p\n  actual   %p", want, frame_ch.data);
        end
      end
    end
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (corner_ch.valid && corner_ch.ready) || (frame_ch.valid && frame_ch.ready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    rst_n = 1'b0;
    corner_ch.valid = 1'b0;
    corner_ch.data = '0;
    frame_ch.ready = 1'b0;
    corners_held = 0;
    held_corner[0] = '0;
    held_corner[1] = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    mismatches = 0;
    hold_asked = 0;
    hold_served = 0;
    hold_left = 0;
    quiet_cycles = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(145, 30, 76);
    test_random(145, 76, 30);
    test_random(140, 0, 0);
    test_backpressure();

    @(negedge clk);
    corner_ch.valid <= 1'b0;
    wait_for_frames();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_frames.size() != 0) mismatches++;
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule
